[design/hann_windowed_fft_magnitude_macros.svh]
// Assertion macros shared by the Hann-windowed FFT magnitude design.
// Used by the controller, the datapath and the square-root unit.
`ifndef HANN_WINDOWED_FFT_MAGNITUDE_MACROS_SVH
`define HANN_WINDOWED_FFT_MAGNITUDE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HWFM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HWFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/hwfm_pkg.sv]
// Package for the Hann-windowed FFT magnitude block: types, widths and the
// elaboration-time builders of the window and twiddle tables. No dependencies.
package hwfm_pkg;

    localparam int MAX_N    = 128;
    localparam int MAX_HALF = MAX_N / 2;
    localparam int IDX_W    = 7;
    localparam int STAGE_W  = 3;
    localparam int SMP_W    = 16;
    localparam int WORD_W   = 24;
    localparam int CPLX_W   = 2 * WORD_W;
    localparam int COEF_W   = 17;
    localparam int SUM_W    = 42;
    localparam int SQ_W     = 48;
    localparam int ROOT_W   = 25;
    localparam int REM_W    = 26;
    localparam int MAG_W    = 22;
    localparam int BIN_W    = 6;
    localparam int SQRT_STEPS = 24;
    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAIN_A,
        ST_DRAIN_B,
        ST_BF_RD,
        ST_BF_MUL,
        ST_BF_ADD,
        ST_BF_WA,
        ST_BF_WB,
        ST_MG_RD,
        ST_MG_MUL,
        ST_MG_SUM,
        ST_MG_SQRT,
        ST_MG_OUT
    } hwfm_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_BF_RD,
        OP_BF_MUL,
        OP_BF_ADD,
        OP_BF_WA,
        OP_BF_WB,
        OP_MG_RD,
        OP_MG_MUL,
        OP_MG_SUM,
        OP_MG_OUT
    } hwfm_op_t;

    typedef struct packed {
        hwfm_op_t             op;
        logic [STAGE_W-1:0]   stage;
        logic [IDX_W-1:0]     idx;
    } hwfm_cmd_t;

    typedef struct packed {
        logic sqrt_done;
    } hwfm_stat_t;

    // Restoring long division, used only while building tables.
    function automatic logic [63:0] hwfm_udiv(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Round to nearest by adding half and shifting right (floor).
    function automatic logic signed [63:0] hwfm_rshift(logic signed [63:0] v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Cosine in the upper half and sine in the lower half, Q30, x in [0, pi/2].
    function automatic logic [127:0] hwfm_taylor(logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        tc;
        logic [63:0]        ts;
        logic signed [63:0] sc;
        logic signed [63:0] ss;
        x2 = (x * x) >> 30;
        tc = Q30_ONE;
        ts = x;
        sc = $signed(Q30_ONE);
        ss = $signed(x);
        for (int k = 1; k <= 8; k++) begin
            tc = hwfm_udiv((tc * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
            ts = hwfm_udiv((ts * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
            if ((k & 1) == 1) begin
                sc = sc - $signed(tc);
                ss = ss - $signed(ts);
            end else begin
                sc = sc + $signed(tc);
                ss = ss + $signed(ts);
            end
        end
        return {sc, ss};
    endfunction

    // Cosine and sine of a phase in Q32 turns, packed as in hwfm_taylor.
    function automatic logic [127:0] hwfm_turn(logic [31:0] ph);
        logic [63:0]  f;
        logic [127:0] cs;
        logic [63:0]  c0;
        logic [63:0]  s0;
        logic [127:0] res;
        f  = {34'd0, ph[29:0]};
        cs = hwfm_taylor((f * HALF_PI_Q30) >> 30);
        c0 = cs[127:64];
        s0 = cs[63:0];
        case (ph[31:30])
            2'd0:    res = {c0, s0};
            2'd1:    res = {-s0, c0};
            2'd2:    res = {-c0, -s0};
            default: res = {s0, -c0};
        endcase
        return res;
    endfunction

    // Hann window, 0..32768, one COEF_W field per entry.
    function automatic logic [MAX_N*COEF_W-1:0] hwfm_win_table(int n);
        logic [MAX_N*COEF_W-1:0] tab;
        logic [63:0]             den;
        logic [63:0]             ph;
        logic [127:0]            cs;
        logic signed [63:0]      v;
        tab = '0;
        den = 64'(n - 1);
        for (int i = 0; i < MAX_N; i++) begin
            if (i < n) begin
                ph = hwfm_udiv((64'(i) << 32) + (den >> 1), den);
                cs = hwfm_turn(ph[31:0]);
                v  = hwfm_rshift($signed(Q30_ONE) - $signed(cs[127:64]), 16);
                if (v < 0) begin
                    v = 0;
                end
                if (v > 64'sd32768) begin
                    v = 64'sd32768;
                end
                tab[i*COEF_W +: COEF_W] = v[COEF_W-1:0];
            end
        end
        return tab;
    endfunction

    // Twiddle cosine (upper half of the packed pair) or sine table.
    function automatic logic [MAX_HALF*COEF_W-1:0] hwfm_tw_table(int n, bit want_sin);
        logic [MAX_HALF*COEF_W-1:0] tab;
        logic [63:0]                ph;
        logic [127:0]               cs;
        logic signed [63:0]         v;
        tab = '0;
        for (int i = 0; i < MAX_HALF; i++) begin
            if (i < n / 2) begin
                ph = hwfm_udiv(64'(i) << 32, 64'(n));
                cs = hwfm_turn(ph[31:0]);
                v  = want_sin ? hwfm_rshift($signed(cs[63:0]), 15)
                              : hwfm_rshift($signed(cs[127:64]), 15);
                if (v < -64'sd32768) begin
                    v = -64'sd32768;
                end
                if (v > 64'sd32768) begin
                    v = 64'sd32768;
                end
                tab[i*COEF_W +: COEF_W] = v[COEF_W-1:0];
            end
        end
        return tab;
    endfunction

endpackage

[design/hwfm_ram.sv]
// Generic simple dual-read RAM: one write port, two registered read ports.
// No dependencies.
module hwfm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[design/hwfm_isqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
// Depends on hwfm_pkg and the assertion macro header.
`include "hann_windowed_fft_magnitude_macros.svh"
module hwfm_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [hwfm_pkg::SQ_W-1:0]   radicand,
    output logic                        done,
    output logic [hwfm_pkg::ROOT_W-1:0] root,
    output logic [hwfm_pkg::REM_W-1:0]  rem
);
    import hwfm_pkg::*;

    logic            run_reg, run_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic [SQ_W-1:0] rem_reg, rem_next;
    logic [SQ_W-1:0] root_reg, root_next;
    logic [SQ_W-1:0] bit_val;
    logic [SQ_W-1:0] trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    always_comb
    begin
        bit_val   = SQ_W'(1) << {cnt_reg, 1'b0};
        trial     = root_reg + bit_val;
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            run_next  = 1'b1;
            cnt_next  = 5'(SQRT_STEPS - 1);
            rem_next  = radicand;
            root_next = '0;
        end
        else if (run_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next  = rem_reg - trial;
                root_next = (root_reg >> 1) + bit_val;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            if (cnt_reg == '0)
            begin
                run_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    assign done = run_reg && (cnt_reg == '0);
    assign root = root_reg[ROOT_W-1:0];
    assign rem  = rem_reg[REM_W-1:0];

    `HWFM_ASSERT_NEXT(a_sqrt_starts, clk, rst_n, start, run_reg && cnt_reg == 5'(SQRT_STEPS - 1), "square root did not start")
    `HWFM_ASSERT_NEXT(a_sqrt_stops, clk, rst_n, done && !start, !run_reg, "square root ran past its last step")

endmodule

[design/hwfm_datapath.sv]
// Datapath: windowing on load, butterfly unit, magnitude unit, result registers.
// Depends on hwfm_pkg, hwfm_ram, hwfm_isqrt and the assertion macro header.
`include "hann_windowed_fft_magnitude_macros.svh"
module hwfm_datapath #(
    parameter int FRAME_SIZE = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hwfm_pkg::hwfm_cmd_t           cmd,
    input  logic signed [hwfm_pkg::SMP_W-1:0] sample,
    output hwfm_pkg::hwfm_stat_t          stat,
    output logic                          result_valid,
    output logic [hwfm_pkg::MAG_W-1:0]    magnitude,
    output logic [hwfm_pkg::BIN_W-1:0]    bin_index,
    output logic                          last_bin
);
    import hwfm_pkg::*;

    localparam int LOG_N = $clog2(FRAME_SIZE);
    localparam int TW_W  = LOG_N - 1;
    localparam int PROD_W = WORD_W + COEF_W;
    localparam int LD_W  = SMP_W + COEF_W + 1;
    localparam logic [MAX_N*COEF_W-1:0]    WIN_TAB = hwfm_win_table(FRAME_SIZE);
    localparam logic [MAX_HALF*COEF_W-1:0] TW_COS  = hwfm_tw_table(FRAME_SIZE, 1'b0);
    localparam logic [MAX_HALF*COEF_W-1:0] TW_SIN  = hwfm_tw_table(FRAME_SIZE, 1'b1);
    localparam logic signed [SUM_W-1:0] W_MAX = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] W_MIN = -SUM_W'(8388608);
    localparam logic [TW_W-1:0] LAST_BIN_IDX = TW_W'(FRAME_SIZE / 2 - 1);

    function automatic logic [WORD_W-1:0] sat_word(logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = v;
        if (v > W_MAX)
        begin
            c = W_MAX;
        end
        if (v < W_MIN)
        begin
            c = W_MIN;
        end
        return c[WORD_W-1:0];
    endfunction

    // Sample load pipeline: capture, multiply by window, round and store.
    logic                     ld_v1_reg, ld_v1_next;
    logic                     ld_v2_reg, ld_v2_next;
    logic signed [SMP_W-1:0]  ld_smp_reg;
    logic [LOG_N-1:0]         ld_idx1_reg;
    logic [LOG_N-1:0]         ld_idx2_reg;
    logic signed [LD_W-1:0]   ld_prod_reg;
    logic [COEF_W-1:0]        win_coef;
    logic signed [LD_W-1:0]   ld_rnd;
    logic [LOG_N-1:0]         ld_rev;

    // Butterfly and magnitude registers.
    logic signed [PROD_W-1:0] p_brc_reg, p_bis_reg, p_bic_reg, p_brs_reg;
    logic signed [WORD_W-1:0] ar_reg, ai_reg;
    logic [CPLX_W-1:0]        new_a_reg, new_b_reg;
    logic [SQ_W-1:0]          sq_re_reg, sq_im_reg;
    logic                     valid_reg, valid_next;
    logic [MAG_W-1:0]         mag_reg;
    logic [BIN_W-1:0]         bin_reg;
    logic                     last_reg;

    logic [LOG_N-1:0]         bfx, half_bit, jmask, jpos, addr_a, addr_b;
    logic [STAGE_W-1:0]       tw_shift;
    logic [LOG_N-1:0]         jsh;
    logic [TW_W-1:0]          tw_idx;
    logic signed [COEF_W-1:0] tw_c, tw_s;
    logic signed [WORD_W-1:0] br, bi, rd_re, rd_im;
    logic signed [SUM_W-1:0]  tsum_r, tsum_i, tr, ti;
    logic [TW_W-1:0]          bin_cur;
    logic [REM_W-1:0]         rounded;

    logic                     we;
    logic [LOG_N-1:0]         waddr, raddr_a, raddr_b;
    logic [CPLX_W-1:0]        wdata, rdata_a, rdata_b;
    logic                     sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]        sqrt_root;
    logic [REM_W-1:0]         sqrt_rem;

    hwfm_ram #(
        .WIDTH (CPLX_W),
        .DEPTH (FRAME_SIZE)
    ) u_work (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    hwfm_isqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sq_re_reg + sq_im_reg),
        .done     (sqrt_done),
        .root     (sqrt_root),
        .rem      (sqrt_rem)
    );

    assign stat.sqrt_done = sqrt_done;
    assign sqrt_start     = (cmd.op == OP_MG_SUM);

    // Butterfly addressing: a = group * 2 * half + j, b = a + half.
    always_comb
    begin
        bfx      = LOG_N'(cmd.idx[LOG_N-2:0]);
        half_bit = LOG_N'(1) << cmd.stage;
        jmask    = half_bit - LOG_N'(1);
        jpos     = bfx & jmask;
        addr_a   = ((bfx & ~jmask) << 1) | jpos;
        addr_b   = addr_a | half_bit;
        tw_shift = STAGE_W'(LOG_N - 1) - cmd.stage;
        jsh      = jpos << tw_shift;
        tw_idx   = jsh[TW_W-1:0];
        tw_c     = $signed(TW_COS[tw_idx*COEF_W +: COEF_W]);
        tw_s     = $signed(TW_SIN[tw_idx*COEF_W +: COEF_W]);
        bin_cur  = cmd.idx[TW_W-1:0];
    end

    always_comb
    begin
        for (int b = 0; b < LOG_N; b++)
        begin
            ld_rev[LOG_N-1-b] = ld_idx2_reg[b];
        end
    end

    assign win_coef   = WIN_TAB[ld_idx1_reg*COEF_W +: COEF_W];
    assign ld_rnd     = (ld_prod_reg + LD_W'(16384)) >>> 15;
    assign ld_v1_next = (cmd.op == OP_LOAD);
    assign ld_v2_next = ld_v1_reg;
    assign valid_next = (cmd.op == OP_MG_OUT);

    always_comb
    begin
        we    = 1'b0;
        waddr = addr_a;
        wdata = new_a_reg;
        if (ld_v2_reg)
        begin
            we    = 1'b1;
            waddr = ld_rev;
            wdata = {{WORD_W{1'b0}}, ld_rnd[WORD_W-1:0]};
        end
        else if (cmd.op == OP_BF_WA)
        begin
            we = 1'b1;
        end
        else if (cmd.op == OP_BF_WB)
        begin
            we    = 1'b1;
            waddr = addr_b;
            wdata = new_b_reg;
        end
        raddr_a = (cmd.op == OP_MG_RD) ? LOG_N'(bin_cur) : addr_a;
        raddr_b = addr_b;
    end

    always_comb
    begin
        br     = $signed(rdata_b[WORD_W-1:0]);
        bi     = $signed(rdata_b[CPLX_W-1:WORD_W]);
        rd_re  = $signed(rdata_a[WORD_W-1:0]);
        rd_im  = $signed(rdata_a[CPLX_W-1:WORD_W]);
        tsum_r = SUM_W'(p_brc_reg) + SUM_W'(p_bis_reg);
        tsum_i = SUM_W'(p_bic_reg) - SUM_W'(p_brs_reg);
        tr     = (tsum_r + SUM_W'(16384)) >>> 15;
        ti     = (tsum_i + SUM_W'(16384)) >>> 15;
        rounded = REM_W'(sqrt_root) + ((sqrt_rem > REM_W'(sqrt_root)) ? REM_W'(1) : REM_W'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_v1_reg <= 1'b0;
            ld_v2_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            ld_v1_reg <= ld_v1_next;
            ld_v2_reg <= ld_v2_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            ld_smp_reg  <= sample;
            ld_idx1_reg <= cmd.idx[LOG_N-1:0];
        end
        if (ld_v1_reg)
        begin
            ld_prod_reg <= LD_W'(ld_smp_reg) * $signed({1'b0, win_coef});
            ld_idx2_reg <= ld_idx1_reg;
        end
        if (cmd.op == OP_BF_MUL)
        begin
            p_brc_reg <= PROD_W'(br) * PROD_W'(tw_c);
            p_bis_reg <= PROD_W'(bi) * PROD_W'(tw_s);
            p_bic_reg <= PROD_W'(bi) * PROD_W'(tw_c);
            p_brs_reg <= PROD_W'(br) * PROD_W'(tw_s);
            ar_reg    <= rd_re;
            ai_reg    <= rd_im;
        end
        if (cmd.op == OP_BF_ADD)
        begin
            new_a_reg <= {sat_word(SUM_W'(ai_reg) + ti), sat_word(SUM_W'(ar_reg) + tr)};
            new_b_reg <= {sat_word(SUM_W'(ai_reg) - ti), sat_word(SUM_W'(ar_reg) - tr)};
        end
        if (cmd.op == OP_MG_MUL)
        begin
            sq_re_reg <= SQ_W'(SQ_W'(rd_re) * SQ_W'(rd_re));
            sq_im_reg <= SQ_W'(SQ_W'(rd_im) * SQ_W'(rd_im));
        end
        if (cmd.op == OP_MG_OUT)
        begin
            mag_reg  <= (rounded > REM_W'(MAG_MAX)) ? MAG_MAX : rounded[MAG_W-1:0];
            bin_reg  <= BIN_W'(bin_cur);
            last_reg <= (bin_cur == LAST_BIN_IDX);
        end
    end

    assign result_valid = valid_reg;
    assign magnitude    = mag_reg;
    assign bin_index    = bin_reg;
    assign last_bin     = last_reg;

    `HWFM_ASSERT_NOW(a_load_write_alone, clk, rst_n, ld_v2_reg, cmd.op != OP_BF_WA && cmd.op != OP_BF_WB, "sample store collides with butterfly write")

endmodule

[design/hwfm_ctrl.sv]
// Controller: frame fill, FFT stage and butterfly sequencing, bin sequencing.
// Depends on hwfm_pkg and the assertion macro header.
`include "hann_windowed_fft_magnitude_macros.svh"
module hwfm_ctrl #(
    parameter int FRAME_SIZE = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  hwfm_pkg::hwfm_stat_t stat,
    output logic                 busy,
    output hwfm_pkg::hwfm_cmd_t  cmd
);
    import hwfm_pkg::*;

    localparam int LOG_N = $clog2(FRAME_SIZE);
    localparam logic [LOG_N-1:0]   LAST_SMP   = LOG_N'(FRAME_SIZE - 1);
    localparam logic [LOG_N-2:0]   LAST_IDX   = (LOG_N-1)'(FRAME_SIZE / 2 - 1);
    localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(LOG_N - 1);

    hwfm_state_t        state_reg, state_next;
    logic [LOG_N-1:0]   cnt_reg, cnt_next;
    logic [LOG_N-2:0]   idx_reg, idx_next;
    logic [STAGE_W-1:0] stage_reg, stage_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            stage_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            stage_reg <= stage_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        stage_next = stage_reg;
        busy       = 1'b1;
        cmd.op     = OP_NONE;
        cmd.stage  = stage_reg;
        cmd.idx    = IDX_W'(idx_reg);
        case (state_reg)
            ST_IDLE:
            begin
                busy    = 1'b0;
                cmd.idx = IDX_W'(cnt_reg);
                if (start)
                begin
                    cmd.op = OP_LOAD;
                    if (cnt_reg == LAST_SMP)
                    begin
                        cnt_next   = '0;
                        state_next = ST_DRAIN_A;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + LOG_N'(1);
                    end
                end
            end
            // The last word is still in the window pipeline during ST_DRAIN_A and ST_DRAIN_B.
            ST_DRAIN_A: state_next = ST_DRAIN_B;
            ST_DRAIN_B: state_next = ST_BF_RD;
            ST_BF_RD:
            begin
                cmd.op     = OP_BF_RD;
                state_next = ST_BF_MUL;
            end
            ST_BF_MUL:
            begin
                cmd.op     = OP_BF_MUL;
                state_next = ST_BF_ADD;
            end
            ST_BF_ADD:
            begin
                cmd.op     = OP_BF_ADD;
                state_next = ST_BF_WA;
            end
            ST_BF_WA:
            begin
                cmd.op     = OP_BF_WA;
                state_next = ST_BF_WB;
            end
            ST_BF_WB:
            begin
                cmd.op     = OP_BF_WB;
                state_next = ST_BF_RD;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next = '0;
                    if (stage_reg == LAST_STAGE)
                    begin
                        stage_next = '0;
                        state_next = ST_MG_RD;
                    end
                    else
                    begin
                        stage_next = stage_reg + STAGE_W'(1);
                    end
                end
                else
                begin
                    idx_next = idx_reg + (LOG_N-1)'(1);
                end
            end
            ST_MG_RD:
            begin
                cmd.op     = OP_MG_RD;
                state_next = ST_MG_MUL;
            end
            ST_MG_MUL:
            begin
                cmd.op     = OP_MG_MUL;
                state_next = ST_MG_SUM;
            end
            ST_MG_SUM:
            begin
                cmd.op     = OP_MG_SUM;
                state_next = ST_MG_SQRT;
            end
            ST_MG_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    state_next = ST_MG_OUT;
                end
            end
            ST_MG_OUT:
            begin
                cmd.op = OP_MG_OUT;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + (LOG_N-1)'(1);
                    state_next = ST_MG_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `HWFM_ASSERT_NEXT(a_frame_goes_busy, clk, rst_n, start && !busy && cnt_reg == LAST_SMP, busy && cnt_reg == '0, "frame end did not start the transform")
    `HWFM_ASSERT_NEXT(a_spectrum_ends, clk, rst_n, state_reg == ST_MG_OUT && idx_reg == LAST_IDX, state_reg == ST_IDLE && idx_reg == '0 && stage_reg == '0, "spectrum did not end on the last bin")

endmodule

[design/hann_windowed_fft_magnitude.sv]
// Samples are taken one per cycle while busy is low; only the last of a frame raises busy.
// It raises busy through the pipeline drain, the transform and all bin magnitudes:
// each butterfly reads, multiplies, adds and writes a and b on the two-read work RAM, and each
// bin reads, squares, sums and runs the two-bit-per-cycle square root, then strobes its result.
// Results come one per strobe and cannot be held off.
// Reset clears the sample count and the sequencer; the work RAM is not cleared.
module hann_windowed_fft_magnitude #(
    parameter int FRAME_SIZE = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [hwfm_pkg::SMP_W-1:0] sample,
    output logic                              result_valid,
    output logic [hwfm_pkg::MAG_W-1:0]        magnitude,
    output logic [hwfm_pkg::BIN_W-1:0]        bin_index,
    output logic                              last_bin
);
    import hwfm_pkg::*;

    hwfm_cmd_t  cmd;
    hwfm_stat_t stat;

    hwfm_ctrl #(
        .FRAME_SIZE (FRAME_SIZE)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    hwfm_datapath #(
        .FRAME_SIZE (FRAME_SIZE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sample       (sample),
        .stat         (stat),
        .result_valid (result_valid),
        .magnitude    (magnitude),
        .bin_index    (bin_index),
        .last_bin     (last_bin)
    );

endmodule

[sim/tb.sv]
// Self-checking bench for hann_windowed_fft_magnitude: frames of samples go in, and the
// bin magnitudes that come out are compared with a fixed-point spectrum predictor.
// Depends on hwfm_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb;

    localparam int N    = 128;
    localparam int HALF = N / 2;
    localparam int LG   = 7;
    localparam int FRAMES = 4;

    typedef struct {
        logic [hwfm_pkg::MAG_W-1:0] mag;
        logic [hwfm_pkg::BIN_W-1:0] bin;
        logic                       last;
    } bin_word_t;

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic signed [hwfm_pkg::SMP_W-1:0] sample;
    logic                              result_valid;
    logic [hwfm_pkg::MAG_W-1:0]        magnitude;
    logic [hwfm_pkg::BIN_W-1:0]        bin_index;
    logic                              last_bin;

    hann_windowed_fft_magnitude #(.FRAME_SIZE(N)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample       (sample),
        .result_valid (result_valid),
        .magnitude    (magnitude),
        .bin_index    (bin_index),
        .last_bin     (last_bin)
    );

    longint win_coef [N];
    longint tw_c [HALF];
    longint tw_s [HALF];
    longint frame_buf [N];
    int     fill_count = 0;
    bin_word_t spectrum_q [$];
    int     errors = 0;
    logic   took = 1'b0;

    // Directed samples: extremes, sign boundaries and single-bit patterns.
    logic signed [15:0] directed_samples [25] = '{
        16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001,
        16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh0000,
        16'sh5555, -16'sh5556, 16'sh4000, -16'sh4000, 16'sh00FF,
        -16'sh0100, 16'sh7FFE, -16'sh7FFF, 16'sh0002, -16'sh0002,
        16'sh1234, -16'sh1235, 16'sh0F0F, -16'sh0F10, 16'sh0000
    };

    always #5 clk = ~clk;

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Q30 cosine and sine of a Q32 phase in turns, by quadrant and Taylor series.
    task automatic phase_cos_sin(input longint unsigned ph, output longint c, output longint s);
        longint unsigned f, x, x2, tc, ts;
        longint          sc, ss;
        f  = ph & 64'h3FFF_FFFF;
        x  = (f * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        tc = 64'd1073741824;
        ts = x;
        sc = 64'sd1073741824;
        ss = longint'(x);
        for (int k = 1; k <= 8; k++) begin
            tc = ((tc * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
            ts = ((ts * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                sc -= longint'(tc);
                ss -= longint'(ts);
            end else begin
                sc += longint'(tc);
                ss += longint'(ts);
            end
        end
        case ((ph >> 30) & 3)
            0: begin c = sc;  s = ss;  end
            1: begin c = -ss; s = sc;  end
            2: begin c = -sc; s = -ss; end
            default: begin c = ss; s = -sc; end
        endcase
    endtask

    task automatic build_coefs();
        longint unsigned den, ph;
        longint          c, s;
        den = N - 1;
        for (int i = 0; i < N; i++) begin
            ph = ((longint'(i) << 32) + den / 2) / den;
            phase_cos_sin(ph & 64'hFFFF_FFFF, c, s);
            win_coef[i] = clip(rnd_shift(64'sd1073741824 - c, 16), 0, 32768);
        end
        for (int i = 0; i < HALF; i++) begin
            ph = (longint'(i) << 32) / N;
            phase_cos_sin(ph, c, s);
            tw_c[i] = clip(rnd_shift(c, 15), -32768, 32768);
            tw_s[i] = clip(rnd_shift(s, 15), -32768, 32768);
        end
    endtask

    function automatic longint unsigned root_nearest(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        if (v > res) res++;
        return res;
    endfunction

    // Windowed radix-2 transform of a full frame; queues one word per bin.
    task automatic predict_spectrum();
        longint    re [N];
        longint    im [N];
        longint    ar, ai, br, bi, tr, ti, c, s;
        int        r, hlf, stp, a, b, t;
        bin_word_t w;
        longint unsigned m;
        for (int i = 0; i < N; i++) begin
            r = 0;
            for (int k = 0; k < LG; k++) r |= ((i >> k) & 1) << (LG - 1 - k);
            re[r] = rnd_shift(frame_buf[i] * win_coef[i], 15);
            im[r] = 0;
        end
        for (int len = 2; len <= N; len <<= 1) begin
            hlf = len >> 1;
            stp = N / len;
            for (int base = 0; base < N; base += len) begin
                for (int j = 0; j < hlf; j++) begin
                    a = base + j;
                    b = a + hlf;
                    t = (j * stp) % HALF;
                    c = tw_c[t];
                    s = tw_s[t];
                    br = re[b]; bi = im[b]; ar = re[a]; ai = im[a];
                    tr = rnd_shift(br * c + bi * s, 15);
                    ti = rnd_shift(bi * c - br * s, 15);
                    re[a] = clip(ar + tr, -8388608, 8388607);
                    im[a] = clip(ai + ti, -8388608, 8388607);
                    re[b] = clip(ar - tr, -8388608, 8388607);
                    im[b] = clip(ai - ti, -8388608, 8388607);
                end
            end
        end
        for (int k = 0; k < HALF; k++) begin
            m = root_nearest(longint'(re[k] * re[k]) + longint'(im[k] * im[k]));
            if (m > 4194303) m = 4194303;
            w.mag  = m[21:0];
            w.bin  = k[5:0];
            w.last = (k == HALF - 1);
            spectrum_q.push_back(w);
        end
    endtask

    // Accepted words feed the predictor; every strobed bin is checked here.
    always @(posedge clk) begin
        bin_word_t e;
        if (rst_n) begin
            took <= start && !busy;
            if (start && !busy) begin
                frame_buf[fill_count] = longint'(sample);
                fill_count++;
                if (fill_count == N) begin
                    fill_count = 0;
                    predict_spectrum();
                end
            end
            if (result_valid) begin
                if (spectrum_q.size() == 0) begin
                    $display("%0t: unexpected bin: mag %0d bin %0d last %0b",
                             $realtime, magnitude, bin_index, last_bin);
                    errors++;
                end else begin
                    e = spectrum_q.pop_front();
                    if (magnitude !== e.mag) begin
                        $display("%0t: bin %0d magnitude expected %0d actual %0d",
                                 $realtime, e.bin, e.mag, magnitude);
                        errors++;
                    end
                    if (bin_index !== e.bin) begin
                        $display("%0t: bin_index expected %0d actual %0d",
                                 $realtime, e.bin, bin_index);
                        errors++;
                    end
                    if (last_bin !== e.last) begin
                        $display("%0t: bin %0d last_bin expected %0b actual %0b",
                                 $realtime, e.bin, e.last, last_bin);
                        errors++;
                    end
                end
            end
        end
    end

    // Sends one word and holds it until the block takes it.
    task automatic send_word(input logic signed [15:0] v);
        start  = 1'b1;
        sample = v;
        do @(negedge clk); while (!took);
    endtask

    int burst_left;

    task automatic pace();
        if (burst_left == 0) begin
            start = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    function automatic logic signed [15:0] frame_sample(int style, int i, int period);
        case (style)
            0: return 16'sh7FFF;
            1: return -16'sh8000;
            2: return (i % 2) ? -16'sh8000 : 16'sh7FFF;
            3: return ((i / period) % 2) ? -16'sh7000 : 16'sh7000;
            4: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int style, period, idx;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        sample = '0;
        burst_left = 0;
        build_coefs();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_samples[i]) begin
            pace();
            send_word(directed_samples[i]);
        end
        idx = 25;
        // The last frame is left half full, so the run also ends mid-frame.
        for (int f = 0; f < FRAMES; f++) begin
            style  = (f == 0) ? 5 : $urandom_range(0, 6);
            period = $urandom_range(1, 16);
            for (; idx < ((f == FRAMES - 1) ? HALF : N); idx++) begin
                pace();
                send_word(frame_sample(style, idx, period));
            end
            idx = 0;
        end
        start = 1'b0;

        while (spectrum_q.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
